/* hdl/ccpse_pkg.sv */
// Package: shared types and constants for the parameter-set extractor.
`timescale 1ns / 1ps

package ccpse_pkg;

   // Codec kind codes
   localparam logic [1:0] CODEC_NONE = 2'd0;
   localparam logic [1:0] CODEC_AVC  = 2'd1;
   localparam logic [1:0] CODEC_HEVC = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_CODEC_KIND    = 1'b0;
   localparam logic CSR_RECORD_LENGTH = 1'b1;

   // Parameter set kinds
   localparam logic [1:0] KIND_VPS  = 2'd0;
   localparam logic [1:0] KIND_SPS  = 2'd1;
   localparam logic [1:0] KIND_PPS  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // Record layout constants
   localparam logic [15:0] AVC_MIN_LEN     = 16'd8;
   localparam logic [15:0] HEVC_MIN_LEN    = 16'd23;
   localparam logic [15:0] AVC_SPS_CNT_POS = 16'd5;
   localparam logic [15:0] HEVC_ARR_CNT_POS = 16'd22;
   localparam logic [7:0]  AVC_CNT_MASK    = 8'h1F;
   localparam logic [7:0]  HEVC_TYPE_MASK  = 8'h3F;
   localparam logic [7:0]  START_LAST_BYTE = 8'h01;
   localparam logic [5:0]  AVC_GT_SPS      = 6'd1;
   localparam logic [5:0]  AVC_GT_PPS      = 6'd2;
   localparam logic [5:0]  HEVC_GT_VPS     = 6'd32;
   localparam logic [5:0]  HEVC_GT_SPS     = 6'd33;
   localparam logic [5:0]  HEVC_GT_PPS     = 6'd34;

   // Output queue geometry (depth is a power of two)
   localparam int QDEPTH = 8;
   localparam int QPTR_W = 3;
   localparam int QCNT_W = 4;
   localparam int MAX_EMIT = 4;

   typedef enum logic [3:0] {
      PH_HDR,
      PH_A_SPS_ENT,
      PH_LEN_LO,
      PH_A_PPS_CNT,
      PH_A_PPS_ENT,
      PH_H_ARR,
      PH_H_CNT_HI,
      PH_H_CNT_LO,
      PH_H_ENT,
      PH_PAY_KEEP,
      PH_PAY_SKIP,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [1:0]  codec_kind;
      logic [15:0] record_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] set_kind;
      logic       unit_first;
      logic       unit_last;
   } result_type;

   // Words produced for one input byte: count is 0, 1 or 4
   typedef struct packed {
      logic [2:0]                  n;
      result_type [MAX_EMIT-1:0]   entry;
   } emit_type;

endpackage

/* hdl/codec_config_param_set_extractor.sv */
// Top level: parameter-set extractor for avcC / hvcC configuration records.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_rec_byte
//   rsp      out  rsp_valid/rsp_stall   rsp_out_byte, rsp_set_kind,
//                                       rsp_unit_first, rsp_unit_last
//   csr      in   csr_we                csr_index, csr_wdata
//
// One record byte is taken per cycle while req is not stalled; its words are written
// into an 8-entry queue, which outputs one word per cycle while rsp is not stalled.
// A length field emits four start-code words at once, so req stalls while fewer
// than four slots are free. Reset is synchronous; any csr write restarts parsing.
`timescale 1ns / 1ps

module codec_config_param_set_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rec_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_set_kind,
   output logic        rsp_unit_first,
   output logic        rsp_unit_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import ccpse_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   emit_type   emit;
   result_type head;
   logic       room;
   logic       not_empty;
   logic       req_accept;
   logic       rsp_accept;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CODEC_KIND:    cfg_in.codec_kind    = csr_wdata[1:0];
            CSR_RECORD_LENGTH: cfg_in.record_length = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= '{CODEC_NONE, 16'd0};
      else
         cfg_ff <= cfg_in;
   end

   // Handshakes
   assign req_stall  = !room;
   assign req_accept = req_valid && room;
   assign rsp_valid  = not_empty;
   assign rsp_accept = not_empty && !rsp_stall;

   ccpse_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_we),
      .accept   (req_accept),
      .rec_byte (req_rec_byte),
      .cfg      (cfg_ff),
      .emit     (emit)
   );

   ccpse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .pop       (rsp_accept),
      .head      (head),
      .not_empty (not_empty),
      .room      (room)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_set_kind   = head.set_kind;
   assign rsp_unit_first = head.unit_first;
   assign rsp_unit_last  = head.unit_last;

endmodule

/* hdl/ccpse_parser.sv */
// Record parser: parse state registers and the per-byte decode logic.
`timescale 1ns / 1ps

module ccpse_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              accept,
   input  logic [7:0]        rec_byte,
   input  ccpse_pkg::cfg_type cfg,
   output ccpse_pkg::emit_type emit
);
   import ccpse_pkg::*;

   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  groups_ff, groups_in;
   logic [15:0] units_ff, units_in;
   logic [15:0] pay_ff, pay_in;
   logic [7:0]  lhigh_ff, lhigh_in;
   logic [5:0]  gtype_ff, gtype_in;
   logic [2:0]  taken_ff, taken_in;

   logic        active;
   logic        step;
   logic        room1, room2, room3;
   logic        len_fits;
   logic [15:0] unit_len;
   logic [15:0] pay_dec;
   logic [1:0]  kind;
   logic        keep;
   phase_type   ph;
   phase_type   after_ph;
   phase_type   long_ph;

   // Kept kind of the current group, KIND_NONE when not kept
   always_comb begin
      kind = KIND_NONE;
      if (cfg.codec_kind == CODEC_AVC) begin
         if (gtype_ff == AVC_GT_SPS)      kind = KIND_SPS;
         else if (gtype_ff == AVC_GT_PPS) kind = KIND_PPS;
      end else begin
         if (gtype_ff == HEVC_GT_VPS)      kind = KIND_VPS;
         else if (gtype_ff == HEVC_GT_SPS) kind = KIND_SPS;
         else if (gtype_ff == HEVC_GT_PPS) kind = KIND_PPS;
      end
   end

   assign keep = (kind != KIND_NONE) && !taken_ff[kind];

   // Where to go after a whole unit, and after a unit that overruns the record
   always_comb begin
      if (cfg.codec_kind == CODEC_AVC) begin
         after_ph = (gtype_ff == AVC_GT_SPS) ? PH_A_SPS_ENT : PH_DONE;
         long_ph  = (gtype_ff == AVC_GT_SPS) ? PH_A_PPS_CNT : PH_DONE;
      end else begin
         after_ph = PH_H_ENT;
         long_ph  = PH_H_ARR;
      end
   end

   // Gating and bounds checks
   assign active = ((cfg.codec_kind == CODEC_AVC) && (cfg.record_length >= AVC_MIN_LEN)) ||
                   ((cfg.codec_kind == CODEC_HEVC) && (cfg.record_length >= HEVC_MIN_LEN));
   assign step   = accept && active && (pos_ff < cfg.record_length);
   assign room1  = ({1'b0, pos_ff} + 17'd1) < {1'b0, cfg.record_length};
   assign room2  = ({1'b0, pos_ff} + 17'd2) < {1'b0, cfg.record_length};
   assign room3  = ({1'b0, pos_ff} + 17'd3) < {1'b0, cfg.record_length};
   assign unit_len = {lhigh_ff, rec_byte};
   assign len_fits = ({2'b0, pos_ff} + 18'd1 + {2'b0, unit_len}) <= {2'b0, cfg.record_length};
   assign pay_dec  = (pay_ff == 16'd0) ? 16'd0 : pay_ff - 16'd1;

   // Next state and emitted words
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      groups_in = groups_ff;
      units_in  = units_ff;
      pay_in    = pay_ff;
      lhigh_in  = lhigh_ff;
      gtype_in  = gtype_ff;
      taken_in  = taken_ff;
      emit      = '0;
      ph        = phase_ff;

      // An entry phase with nothing left falls through on the same byte
      if ((phase_ff == PH_A_SPS_ENT || phase_ff == PH_A_PPS_ENT || phase_ff == PH_H_ENT) &&
          !((units_ff != 16'd0) && room2)) begin
         if (phase_ff == PH_A_SPS_ENT)  ph = PH_A_PPS_CNT;
         else if (phase_ff == PH_H_ENT) ph = PH_H_ARR;
         else                           ph = PH_DONE;
      end

      if (clear) begin
         pos_in    = '0;
         phase_in  = PH_HDR;
         groups_in = '0;
         units_in  = '0;
         pay_in    = '0;
         lhigh_in  = '0;
         gtype_in  = '0;
         taken_in  = '0;
      end else if (step) begin
         pos_in = pos_ff + 16'd1;
         unique case (ph)
            PH_HDR: begin
               if (cfg.codec_kind == CODEC_AVC && pos_ff == AVC_SPS_CNT_POS) begin
                  units_in = {8'd0, rec_byte & AVC_CNT_MASK};
                  gtype_in = AVC_GT_SPS;
                  phase_in = PH_A_SPS_ENT;
               end else if (cfg.codec_kind == CODEC_HEVC && pos_ff == HEVC_ARR_CNT_POS) begin
                  groups_in = rec_byte;
                  phase_in  = PH_H_ARR;
               end
            end
            PH_A_SPS_ENT, PH_A_PPS_ENT, PH_H_ENT: begin
               units_in = units_ff - 16'd1;
               lhigh_in = rec_byte;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (!len_fits) begin
                  phase_in = long_ph;
               end else begin
                  if (keep) begin
                     taken_in       = taken_ff | (3'b001 << kind);
                     emit.n         = 3'd4;
                     emit.entry[0]  = '{8'h00, kind, 1'b1, 1'b0};
                     emit.entry[1]  = '{8'h00, kind, 1'b0, 1'b0};
                     emit.entry[2]  = '{8'h00, kind, 1'b0, 1'b0};
                     emit.entry[3]  = '{START_LAST_BYTE, kind, 1'b0, unit_len == 16'd0};
                  end
                  pay_in = unit_len;
                  if (unit_len == 16'd0)
                     phase_in = after_ph;
                  else
                     phase_in = keep ? PH_PAY_KEEP : PH_PAY_SKIP;
               end
            end
            PH_A_PPS_CNT: begin
               if (room1) begin
                  units_in = {8'd0, rec_byte};
                  gtype_in = AVC_GT_PPS;
                  phase_in = PH_A_PPS_ENT;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_H_ARR: begin
               if (groups_ff != 8'd0 && room3) begin
                  groups_in = groups_ff - 8'd1;
                  gtype_in  = rec_byte[5:0] & HEVC_TYPE_MASK[5:0];
                  phase_in  = PH_H_CNT_HI;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_H_CNT_HI: begin
               lhigh_in = rec_byte;
               phase_in = PH_H_CNT_LO;
            end
            PH_H_CNT_LO: begin
               units_in = {lhigh_ff, rec_byte};
               phase_in = PH_H_ENT;
            end
            PH_PAY_KEEP, PH_PAY_SKIP: begin
               pay_in = pay_dec;
               if (ph == PH_PAY_KEEP) begin
                  emit.n        = 3'd1;
                  emit.entry[0] = '{rec_byte, kind, 1'b0, pay_dec == 16'd0};
               end
               if (pay_dec == 16'd0)
                  phase_in = after_ph;
            end
            PH_DONE: phase_in = PH_DONE;
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_HDR;
         groups_ff <= '0;
         units_ff  <= '0;
         pay_ff    <= '0;
         lhigh_ff  <= '0;
         gtype_ff  <= '0;
         taken_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         groups_ff <= groups_in;
         units_ff  <= units_in;
         pay_ff    <= pay_in;
         lhigh_ff  <= lhigh_in;
         gtype_ff  <= gtype_in;
         taken_ff  <= taken_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Words only come from a length field or a kept payload byte
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      (emit.n != 3'd0) |-> (phase_ff == PH_LEN_LO || phase_ff == PH_PAY_KEEP || ph == PH_LEN_LO))
      else $error("parser emitted outside a unit");
   // Either nothing, one payload byte or a full start code
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      emit.n == 3'd0 || emit.n == 3'd1 || emit.n == 3'd4)
      else $error("bad emit count");
   // The byte position never passes the record end
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cfg.record_length)
      else $error("byte position past record end");
`endif

endmodule

/* hdl/ccpse_queue.sv */
// Result queue: takes up to four words per cycle, delivers one per cycle when popped.
`timescale 1ns / 1ps

module ccpse_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  ccpse_pkg::emit_type     push,
   input  logic                    pop,
   output ccpse_pkg::result_type   head,
   output logic                    not_empty,
   output logic                    room
);
   import ccpse_pkg::*;

   result_type        q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0] q_wr_ff, q_wr_in;
   logic [QPTR_W-1:0] q_rd_ff, q_rd_in;
   logic [QCNT_W-1:0] q_count_ff, q_count_in;

   // Pointer and fill count update
   always_comb begin
      q_wr_in    = q_wr_ff + QPTR_W'(push.n);
      q_rd_in    = pop ? q_rd_ff + QPTR_W'(1) : q_rd_ff;
      q_count_in = q_count_ff + QCNT_W'(push.n) - QCNT_W'(pop);
   end

   assign head      = q_mem_ff[q_rd_ff];
   assign not_empty = (q_count_ff != '0);
   assign room      = (q_count_ff <= QCNT_W'(QDEPTH - MAX_EMIT));

   // Storage: entries land at consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_EMIT; i++) begin
         if (3'(i) < push.n)
            q_mem_ff[q_wr_ff + QPTR_W'(i)] <= push.entry[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         q_wr_ff    <= q_wr_in;
         q_rd_ff    <= q_rd_in;
         q_count_ff <= q_count_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Fill count stays within the storage
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCNT_W'(QDEPTH))
      else $error("queue overflow");
   // A lone pop removes exactly one word
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && push.n == 3'd0) |=> (q_count_ff == $past(q_count_ff) - QCNT_W'(1)))
      else $error("queue count slip on pop");
`endif

endmodule

/* test/tb_codec_config_param_set_extractor.sv */
// Testbench: drives avcC/hvcC record bytes into the parameter-set extractor and checks its words.
`timescale 1ns / 1ps

module tb_codec_config_param_set_extractor;
   import ccpse_pkg::*;

   localparam logic [1:0] CODEC_UNUSED = 2'd3;
   localparam int ITEM_TARGET   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 100;
   localparam int SCRIPT_ROWS   = 25;

   // Directed rows: register write, checked byte, or byte that must yield no word
   typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_SILENT} row_op_type;
   typedef struct packed {
      row_op_type  op;
      logic        idx;
      logic [15:0] value;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rec_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_set_kind;
   logic        rsp_unit_first;
   logic        rsp_unit_last;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   // Predicted parser state and configuration
   logic [1:0]  cfg_codec = CODEC_NONE;
   logic [15:0] cfg_len = 16'h0000;
   logic [15:0] rec_pos;
   phase_type   rec_phase;
   logic [7:0]  arrays_left;
   logic [15:0] entries_left;
   logic [15:0] pay_left;
   logic [7:0]  len_hi;
   logic [5:0]  group_id;
   logic [2:0]  taken_sets;

   result_type  annexb_words[$];
   result_type  head_word;
   logic [7:0]  rec_image[$];
   int          items_sent = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   row_type script [SCRIPT_ROWS] = '{
      // after reset: no codec, nothing comes out
      {ROW_SILENT, 1'b0, 16'h0000},
      {ROW_SILENT, 1'b0, 16'h00FF},
      // AVC record one byte too short
      {ROW_WRITE, CSR_CODEC_KIND, 14'd0, CODEC_AVC},
      {ROW_WRITE, CSR_RECORD_LENGTH, AVC_MIN_LEN - 16'd1},
      {ROW_SILENT, 1'b0, 16'h005A},
      // AVC: one SPS of one byte, one empty PPS
      {ROW_WRITE, CSR_RECORD_LENGTH, 16'd13},
      {ROW_BYTE, 1'b0, 16'h0001},
      {ROW_BYTE, 1'b0, 16'h0064},
      {ROW_BYTE, 1'b0, 16'h0000},
      {ROW_BYTE, 1'b0, 16'h001F},
      {ROW_BYTE, 1'b0, 16'h00FF},
      {ROW_BYTE, 1'b0, 16'h00E1},
      {ROW_BYTE, 1'b0, 16'h0000},
      {ROW_BYTE, 1'b0, 16'h0001},
      {ROW_BYTE, 1'b0, 16'h0067},
      {ROW_BYTE, 1'b0, 16'h0001},
      {ROW_BYTE, 1'b0, 16'h0000},
      {ROW_BYTE, 1'b0, 16'h0000},
      {ROW_BYTE, 1'b0, 16'h0080},
      // past the record end
      {ROW_SILENT, 1'b0, 16'h00AA},
      // reserved codec code
      {ROW_WRITE, CSR_CODEC_KIND, 14'd0, CODEC_UNUSED},
      {ROW_SILENT, 1'b0, 16'h0001},
      // HEVC record one byte too short
      {ROW_WRITE, CSR_CODEC_KIND, 14'd0, CODEC_HEVC},
      {ROW_WRITE, CSR_RECORD_LENGTH, HEVC_MIN_LEN - 16'd1},
      {ROW_SILENT, 1'b0, 16'h0033}
   };

   codec_config_param_set_extractor u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rec_byte   (req_rec_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_set_kind   (rsp_set_kind),
      .rsp_unit_first (rsp_unit_first),
      .rsp_unit_last  (rsp_unit_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR %0t: %s", $time, msg);
   endtask

   task automatic clear_parse();
      rec_pos = 16'h0000;
      rec_phase = PH_HDR;
      arrays_left = 8'h00;
      entries_left = 16'h0000;
      pay_left = 16'h0000;
      len_hi = 8'h00;
      group_id = 6'd0;
      taken_sets = 3'b000;
   endtask

   task automatic push_word(input logic [7:0] b, input logic [1:0] kind,
                            input logic first, input logic last);
      result_type w;
      w.out_byte = b;
      w.set_kind = kind;
      w.unit_first = first;
      w.unit_last = last;
      annexb_words.push_back(w);
   endtask

   // Set kind of the unit being parsed; KIND_NONE when it is not kept
   function automatic logic [1:0] unit_kind();
      logic [5:0] off;
      off = group_id - HEVC_GT_VPS;
      if (cfg_codec == CODEC_AVC)
         return (group_id == AVC_GT_SPS || group_id == AVC_GT_PPS) ? group_id[1:0] : KIND_NONE;
      return (group_id >= HEVC_GT_VPS && group_id <= HEVC_GT_PPS) ? off[1:0] : KIND_NONE;
   endfunction

   task automatic finish_unit();
      if (cfg_codec == CODEC_AVC)
         rec_phase = (group_id == AVC_GT_SPS) ? PH_A_SPS_ENT : PH_DONE;
      else
         rec_phase = PH_H_ENT;
   endtask

   // Predictor: advance the parser by one accepted byte, queue the words it yields
   task automatic parse_record_byte(input logic [7:0] b);
      int p, lim, len, guard;
      logic again, keep;
      logic [1:0] kind;
      p = int'(rec_pos);
      lim = int'(cfg_len);
      if (cfg_codec == CODEC_AVC) begin
         if (lim < int'(AVC_MIN_LEN)) return;
      end else if (cfg_codec == CODEC_HEVC) begin
         if (lim < int'(HEVC_MIN_LEN)) return;
      end else begin
         return;
      end
      if (p >= lim) return;
      rec_pos = rec_pos + 16'd1;
      again = 1'b1;
      guard = 0;
      while (again && guard < 8) begin
         again = 1'b0;
         guard++;
         case (rec_phase)
            PH_HDR: begin
               if (cfg_codec == CODEC_AVC && p == int'(AVC_SPS_CNT_POS)) begin
                  entries_left = {11'd0, b[4:0] & AVC_CNT_MASK[4:0]};
                  group_id = AVC_GT_SPS;
                  rec_phase = PH_A_SPS_ENT;
               end else if (cfg_codec == CODEC_HEVC && p == int'(HEVC_ARR_CNT_POS)) begin
                  arrays_left = b;
                  rec_phase = PH_H_ARR;
               end
            end
            PH_A_SPS_ENT, PH_A_PPS_ENT, PH_H_ENT: begin
               if (entries_left != 16'd0 && p + 2 < lim) begin
                  entries_left = entries_left - 16'd1;
                  len_hi = b;
                  rec_phase = PH_LEN_LO;
               end else begin
                  // list exhausted or too little record left: same byte goes on
                  if (rec_phase == PH_A_SPS_ENT) rec_phase = PH_A_PPS_CNT;
                  else if (rec_phase == PH_H_ENT) rec_phase = PH_H_ARR;
                  else rec_phase = PH_DONE;
                  again = 1'b1;
               end
            end
            PH_LEN_LO: begin
               len = int'({len_hi, b});
               if (p + 1 + len > lim) begin
                  // unit overruns the record
                  if (cfg_codec == CODEC_AVC)
                     rec_phase = (group_id == AVC_GT_SPS) ? PH_A_PPS_CNT : PH_DONE;
                  else
                     rec_phase = PH_H_ARR;
               end else begin
                  kind = unit_kind();
                  keep = (kind != KIND_NONE) && !taken_sets[kind];
                  if (keep) begin
                     taken_sets[kind] = 1'b1;
                     push_word(8'h00, kind, 1'b1, 1'b0);
                     push_word(8'h00, kind, 1'b0, 1'b0);
                     push_word(8'h00, kind, 1'b0, 1'b0);
                     push_word(START_LAST_BYTE, kind, 1'b0, len == 0);
                  end
                  pay_left = len[15:0];
                  if (len == 0) finish_unit();
                  else rec_phase = keep ? PH_PAY_KEEP : PH_PAY_SKIP;
               end
            end
            PH_A_PPS_CNT: begin
               if (p + 1 < lim) begin
                  entries_left = {8'd0, b};
                  group_id = AVC_GT_PPS;
                  rec_phase = PH_A_PPS_ENT;
               end else begin
                  rec_phase = PH_DONE;
               end
            end
            PH_H_ARR: begin
               if (arrays_left != 8'd0 && p + 3 < lim) begin
                  arrays_left = arrays_left - 8'd1;
                  group_id = b[5:0] & HEVC_TYPE_MASK[5:0];
                  rec_phase = PH_H_CNT_HI;
               end else begin
                  rec_phase = PH_DONE;
               end
            end
            PH_H_CNT_HI: begin
               len_hi = b;
               rec_phase = PH_H_CNT_LO;
            end
            PH_H_CNT_LO: begin
               entries_left = {len_hi, b};
               rec_phase = PH_H_ENT;
            end
            PH_PAY_KEEP, PH_PAY_SKIP: begin
               if (pay_left != 16'd0) pay_left = pay_left - 16'd1;
               if (rec_phase == PH_PAY_KEEP)
                  push_word(b, unit_kind(), 1'b0, pay_left == 16'd0);
               if (pay_left == 16'd0) finish_unit();
            end
            default: ;
         endcase
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rec_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
      parse_record_byte(b);
   endtask

   // Hold off the sender until every predicted word has come out
   task automatic drain_output();
      req_valid <= 1'b0;
      @(negedge clock);
      while (annexb_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CODEC_KIND) cfg_codec = v[1:0];
      else cfg_len = v;
      clear_parse();
      @(negedge clock);
   endtask

   // Length field plus payload; now and then a length that overruns the record
   task automatic add_unit();
      int r, len;
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(0, 6);
      else if (r < 95) len = $urandom_range(7, 40);
      else len = $urandom_range(0, 65535);
      rec_image.push_back(len[15:8]);
      rec_image.push_back(len[7:0]);
      repeat (len < 64 ? len : 3) rec_image.push_back(rand_byte());
   endtask

   // Receiver stalls: runs of free cycles, otherwise random stall bursts
   initial begin
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(50, 200)) @(negedge clock) rsp_stall <= 1'b0;
         end else begin
            repeat (pick_gap()) @(negedge clock) rsp_stall <= 1'b1;
            @(negedge clock) rsp_stall <= 1'b0;
         end
      end
   end

   // Word checker: oldest prediction against each accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (annexb_words.size() == 0) begin
            flag_error($sformatf("unexpected word %02h", rsp_out_byte));
         end else begin
            head_word = annexb_words.pop_front();
            if (rsp_out_byte !== head_word.out_byte)
               flag_error($sformatf("out_byte %02h, want %02h", rsp_out_byte,
                                    head_word.out_byte));
            if (rsp_set_kind !== head_word.set_kind)
               flag_error($sformatf("set_kind %0d, want %0d", rsp_set_kind,
                                    head_word.set_kind));
            if (rsp_unit_first !== head_word.unit_first)
               flag_error($sformatf("unit_first %0b, want %0b", rsp_unit_first,
                                    head_word.unit_first));
            if (rsp_unit_last !== head_word.unit_last)
               flag_error($sformatf("unit_last %0b, want %0b", rsp_unit_last,
                                    head_word.unit_last));
         end
      end
   end

   // Watchdog: too long without any handshake or register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int r, n, t, size, min_len, rlen, pause_at, phase_no, n0;
      logic burst;
      logic [1:0] codec;
      logic [7:0] rb;
      logic [15:0] codec_word;

      clear_parse();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed rows
      foreach (script[i]) begin
         case (script[i].op)
            ROW_WRITE: begin
               drain_output();
               csr_write(script[i].idx, script[i].value);
            end
            ROW_BYTE: send_byte(script[i].value[7:0], pick_gap());
            default: begin
               // expected by inspection: no word at all
               n0 = annexb_words.size();
               send_byte(script[i].value[7:0], pick_gap());
               while (annexb_words.size() > n0) void'(annexb_words.pop_back());
            end
         endcase
      end

      // Random records, mostly well formed
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         phase_no++;
         r = $urandom_range(0, 99);
         codec = (r < 45) ? CODEC_AVC : (r < 92) ? CODEC_HEVC :
                 (r < 96) ? CODEC_NONE : CODEC_UNUSED;
         if (phase_no == 3) codec = CODEC_HEVC;
         rec_image.delete();
         if (codec == CODEC_HEVC) begin
            repeat (22) rec_image.push_back(rand_byte());
            r = $urandom_range(0, 99);
            n = (r < 85) ? $urandom_range(1, 4) : (r < 92) ? 0 : $urandom_range(0, 255);
            rec_image.push_back(n[7:0]);
            repeat (n < 5 ? n : 5) begin
               r = $urandom_range(0, 99);
               t = (r < 80) ? $urandom_range(32, 34) : $urandom_range(0, 63);
               rb = rand_byte();
               rec_image.push_back({rb[7:6], t[5:0]});
               r = $urandom_range(0, 99);
               t = (r < 85) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
               rec_image.push_back(t[15:8]);
               rec_image.push_back(t[7:0]);
               repeat (t < 4 ? t : 3) add_unit();
            end
         end else begin
            // avcC layout, also fed while no valid codec is set
            repeat (5) rec_image.push_back(rand_byte());
            r = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 3) : (r < 85) ? 0 : $urandom_range(0, 31);
            rb = rand_byte();
            rec_image.push_back({rb[7:5], n[4:0]});
            repeat (n < 4 ? n : 4) add_unit();
            r = $urandom_range(0, 99);
            n = (r < 80) ? $urandom_range(1, 2) : (r < 90) ? 0 : $urandom_range(0, 255);
            rec_image.push_back(n[7:0]);
            repeat (n < 3 ? n : 2) add_unit();
         end

         // Record length: exact, short, truncated or padded
         min_len = (codec == CODEC_HEVC) ? int'(HEVC_MIN_LEN) : int'(AVC_MIN_LEN);
         size = rec_image.size();
         r = $urandom_range(0, 99);
         if (phase_no == 3) begin
            rlen = 65535;
         end else if (r < 70) begin
            rlen = size;
         end else if (r < 80) begin
            rlen = $urandom_range(0, min_len);
         end else if (r < 90) begin
            rlen = (size > min_len) ? $urandom_range(min_len, size - 1) : size;
         end else begin
            rlen = size + $urandom_range(1, 5);
            while (rec_image.size() < rlen) rec_image.push_back(rand_byte());
         end
         repeat ($urandom_range(0, 3)) rec_image.push_back(rand_byte());

         rb = rand_byte();
         codec_word = {8'd0, ($urandom_range(0, 4) == 0) ? rb[5:0] : 6'd0, codec};
         drain_output();
         if ($urandom_range(0, 1) == 1) begin
            csr_write(CSR_CODEC_KIND, codec_word);
            csr_write(CSR_RECORD_LENGTH, rlen[15:0]);
         end else begin
            csr_write(CSR_RECORD_LENGTH, rlen[15:0]);
            csr_write(CSR_CODEC_KIND, codec_word);
         end

         burst = ($urandom_range(0, 3) == 0);
         pause_at = (phase_no == 1 || $urandom_range(0, 4) == 0) ?
                    $urandom_range(0, rec_image.size() - 1) : -1;
         foreach (rec_image[i]) begin
            if (i == pause_at) drain_output();
            send_byte(rec_image[i], burst ? 0 : pick_gap());
         end
      end

      drain_output();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
